// ===== design/jacobi_symmetric_eigen_3x3_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 symmetric eigen unit.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef JACOBI_SYMMETRIC_EIGEN_3X3_UNIT_ASSERT_SVH
`define JACOBI_SYMMETRIC_EIGEN_3X3_UNIT_ASSERT_SVH

// Same-cycle implication.
`define JSE3_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("jse3 assertion failed");

// Next-cycle implication.
`define JSE3_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("jse3 assertion failed");

`endif

// ===== design/jse3_pkg.sv =====
// ----------------------------------------------------------------------------
// jse3_pkg
// Shared types, constants and helpers of the 3x3 symmetric eigen unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse3_pkg;

  localparam int DATA_BITS_DEF = 32;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int SWEEP_BITS    = 6;
  localparam int THR_BITS      = 16;
  localparam int SHIFT_BITS    = 5;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SWEEPS       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEGLIGIBLE_SHIFT = 2'd2;

  localparam logic [SWEEP_BITS-1:0] MAX_SWEEPS_RST       = 6'd20;
  localparam logic [THR_BITS-1:0]   ZERO_THRESHOLD_RST   = 16'd1;
  localparam logic [SHIFT_BITS-1:0] NEGLIGIBLE_SHIFT_RST = 5'd24;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_DIV,
    AR_SQRT
  } arith_mode_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SETUP,
    OP_NORM,
    OP_MUL_AA,
    OP_MUL_BB,
    OP_SQRT,
    OP_DIV_TM,
    OP_MUL_TT,
    OP_DIV_C,
    OP_MUL_S,
    OP_DIV_TAU,
    OP_MUL_TA,
    OP_DIAG,
    OP_T1,
    OP_T2,
    OP_T3,
    OP_T4,
    OP_WB,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
    logic [1:0] pair;
  } dp_cmd_t;

  typedef struct packed {
    logic arith_done;
    logic norm_more;
    logic small_ang;
    logic sum_small;
    logic piv_big;
  } dp_stat_t;

  function automatic logic [1:0] piv_p(input logic [1:0] idx);
    case (idx)
      2'd0:    piv_p = 2'd1;
      2'd1:    piv_p = 2'd2;
      default: piv_p = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] piv_q(input logic [1:0] idx);
    case (idx)
      2'd0:    piv_q = 2'd2;
      2'd1:    piv_q = 2'd0;
      default: piv_q = 2'd1;
    endcase
  endfunction

endpackage

// ===== design/jse3_in_if.sv =====
// ----------------------------------------------------------------------------
// jse3_in_if
// Request channel carrying one symmetric 3x3 matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse3_in_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] diag_0;
  logic signed [DATA_BITS-1:0] diag_1;
  logic signed [DATA_BITS-1:0] diag_2;
  logic signed [DATA_BITS-1:0] off_21;
  logic signed [DATA_BITS-1:0] off_02;
  logic signed [DATA_BITS-1:0] off_10;

  modport source (output valid, diag_0, diag_1, diag_2, off_21, off_02, off_10,
                  input ready);
  modport sink (input valid, diag_0, diag_1, diag_2, off_21, off_02, off_10,
                output ready);
endinterface

// ===== design/jse3_out_if.sv =====
// ----------------------------------------------------------------------------
// jse3_out_if
// Result channel carrying eigenvalues and eigenvector rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse3_out_if #(
  parameter int DATA_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [DATA_BITS-1:0] eigval_0;
  logic signed [DATA_BITS-1:0] eigval_1;
  logic signed [DATA_BITS-1:0] eigval_2;
  logic signed [DATA_BITS-1:0] vec0_x;
  logic signed [DATA_BITS-1:0] vec0_y;
  logic signed [DATA_BITS-1:0] vec0_z;
  logic signed [DATA_BITS-1:0] vec1_x;
  logic signed [DATA_BITS-1:0] vec1_y;
  logic signed [DATA_BITS-1:0] vec1_z;
  logic signed [DATA_BITS-1:0] vec2_x;
  logic signed [DATA_BITS-1:0] vec2_y;
  logic signed [DATA_BITS-1:0] vec2_z;

  modport source (output valid, eigval_0, eigval_1, eigval_2,
                  vec0_x, vec0_y, vec0_z, vec1_x, vec1_y, vec1_z,
                  vec2_x, vec2_y, vec2_z,
                  input ready);
  modport sink (input valid, eigval_0, eigval_1, eigval_2,
                vec0_x, vec0_y, vec0_z, vec1_x, vec1_y, vec1_z,
                vec2_x, vec2_y, vec2_z,
                output ready);
endinterface

// ===== design/jse3_arith.sv =====
// ----------------------------------------------------------------------------
// jse3_arith
// Shared iterative unit: two-step 64x32 multiply, restoring divide and
// square root, one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse3_arith
  import jse3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  arith_mode_t mode,
  input  logic [63:0] opa,
  input  logic [33:0] opb,
  output logic        done,
  output logic [95:0] res
);

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  arith_mode_t mode_r;
  logic [63:0] x_r;
  logic [33:0] b_r;
  logic [95:0] acc_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;

  logic        last;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [35:0] div_sh;
  logic        div_ge;
  logic [35:0] sq_sh;
  logic [35:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    case (mode_r)
      AR_MUL:  last = (cnt_r == 6'd1);
      AR_SQRT: last = (cnt_r == 6'd31);
      default: last = (cnt_r == 6'd63);
    endcase
    mul_a    = cnt_r[0] ? x_r[63:32] : x_r[31:0];
    prod     = 64'(mul_a) * 64'(b_r[31:0]);
    div_sh   = {rem_r[34:0], x_r[63]};
    div_ge   = (div_sh >= {2'b00, b_r});
    sq_sh    = {rem_r[33:0], x_r[63:62]};
    sq_trial = {2'b00, root_r, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= AR_MUL;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mode_r <= mode;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= opa;
      b_r    <= opb;
      acc_r  <= '0;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      case (mode_r)
        AR_MUL: begin
          if (cnt_r[0]) begin
            acc_r <= acc_r + {prod, 32'd0};
          end else begin
            acc_r <= {32'd0, prod};
          end
        end
        AR_DIV: begin
          x_r   <= {x_r[62:0], 1'b0};
          acc_r <= {acc_r[94:0], div_ge};
          rem_r <= div_ge ? (div_sh - {2'b00, b_r}) : div_sh;
        end
        default: begin
          x_r    <= {x_r[61:0], 2'b00};
          rem_r  <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
          root_r <= {root_r[30:0], sq_ge};
        end
      endcase
    end
  end

  always_comb begin
    case (mode_r)
      AR_MUL:  res = acc_r;
      AR_DIV:  res = {32'd0, acc_r[63:0]};
      default: res = {64'd0, root_r};
    endcase
  end

  assign done = done_r;

endmodule

// ===== design/jse3_dpath.sv =====
// ----------------------------------------------------------------------------
// jse3_dpath
// Matrix and rotation registers of the Jacobi solver, with the shared
// arithmetic unit and the result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse3_dpath
  import jse3_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_stat_t                    stat,
  input  logic [THR_BITS-1:0]         zero_thr,
  input  logic [SHIFT_BITS-1:0]       neg_shift,
  input  logic signed [DATA_BITS-1:0] diag_0,
  input  logic signed [DATA_BITS-1:0] diag_1,
  input  logic signed [DATA_BITS-1:0] diag_2,
  input  logic signed [DATA_BITS-1:0] off_21,
  input  logic signed [DATA_BITS-1:0] off_02,
  input  logic signed [DATA_BITS-1:0] off_10,
  output logic signed [DATA_BITS-1:0] eigval_0,
  output logic signed [DATA_BITS-1:0] eigval_1,
  output logic signed [DATA_BITS-1:0] eigval_2,
  output logic signed [DATA_BITS-1:0] vec0_x,
  output logic signed [DATA_BITS-1:0] vec0_y,
  output logic signed [DATA_BITS-1:0] vec0_z,
  output logic signed [DATA_BITS-1:0] vec1_x,
  output logic signed [DATA_BITS-1:0] vec1_y,
  output logic signed [DATA_BITS-1:0] vec1_z,
  output logic signed [DATA_BITS-1:0] vec2_x,
  output logic signed [DATA_BITS-1:0] vec2_y,
  output logic signed [DATA_BITS-1:0] vec2_z
);

  localparam int IW = (DATA_BITS + 10 > 36) ? DATA_BITS + 10 : 36;
  localparam int UW = 33;
  localparam logic signed [IW-1:0] LIM_M   = IW'(1) <<< (DATA_BITS + 6);
  localparam logic signed [IW-1:0] LIM_U   = IW'(1) <<< 31;
  localparam logic signed [IW-1:0] VEC_ONE = IW'(1) <<< 30;
  localparam logic signed [IW-1:0] EMAX    = (IW'(1) <<< (DATA_BITS - 1)) - IW'(1);
  localparam logic signed [IW-1:0] EMIN    = -EMAX - IW'(1);
  localparam logic [63:0]          ONE_60  = 64'd1 << 60;
  localparam logic [30:0]          ONE_30  = 31'd1 << 30;

  function automatic logic signed [IW-1:0] clampv(input logic signed [IW-1:0] v,
                                                  input logic signed [IW-1:0] lim);
    if (v > lim) begin
      clampv = lim;
    end else if (v < -lim) begin
      clampv = -lim;
    end else begin
      clampv = v;
    end
  endfunction

  function automatic logic [IW-1:0] magi(input logic signed [IW-1:0] v);
    magi = v[IW-1] ? IW'(-v) : IW'(v);
  endfunction

  function automatic logic signed [IW-1:0] sxu(input logic signed [UW-1:0] v);
    sxu = {{(IW-UW){v[UW-1]}}, v};
  endfunction

  logic signed [IW-1:0] dg_r [3];
  logic signed [IW-1:0] od_r [3];
  logic signed [UW-1:0] um_r [3][3];
  logic signed [IW-1:0] piv_r;
  logic [IW-1:0]        a_r;
  logic [IW-1:0]        b_r;
  logic                 small_r;
  logic                 neg_r;
  logic [63:0]          sq_r;
  logic [31:0]          r_r;
  logic [30:0]          tm_r;
  logic [30:0]          c_r;
  logic signed [31:0]   s_r;
  logic signed [31:0]   tau_r;
  logic signed [IW-1:0] ta_r;
  logic signed [IW-1:0] t1_r;
  logic signed [IW-1:0] t2_r;
  logic signed [IW-1:0] t3_r;
  logic signed [IW-1:0] t4_r;
  dp_op_t               pend_r;
  logic                 msign_r;
  logic signed [DATA_BITS-1:0] eig_r [3];
  logic signed [DATA_BITS-1:0] vec_r [3][3];

  logic [1:0]           p;
  logic [1:0]           q;
  logic [1:0]           col;
  logic signed [IW-1:0] xv;
  logic signed [IW-1:0] yv;
  logic signed [IW-1:0] h;
  logic [IW-1:0]        ah;
  logic [IW-1:0]        ao;
  logic [IW+6:0]        ao100;
  logic                 small_nxt;
  logic signed [31:0]   tv;
  logic signed [IW-1:0] mv;
  logic signed [31:0]   mf;
  logic [31:0]          mf_mag;
  logic [IW+1:0]        od_sum;
  logic                 ar_start;
  arith_mode_t          ar_mode;
  logic [63:0]          ar_a;
  logic [33:0]          ar_b;
  logic                 ar_done;
  logic [95:0]          ar_res;
  logic [IW-1:0]        mq_mag;
  logic signed [IW-1:0] mq;
  logic [33:0]          den_t;

  jse3_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start),
    .mode  (ar_mode),
    .opa   (ar_a),
    .opb   (ar_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  always_comb begin
    p     = piv_p(cmd.idx);
    q     = piv_q(cmd.idx);
    col   = 2'(2'd3 - cmd.pair);
    if (cmd.pair == 2'd0) begin
      xv = od_r[q];
      yv = od_r[p];
    end else begin
      xv = sxu(um_r[p][col]);
      yv = sxu(um_r[q][col]);
    end
    h         = dg_r[q] - dg_r[p];
    ah        = magi(h);
    ao        = magi(od_r[cmd.idx]);
    ao100     = {1'b0, ao, 6'd0} + {2'b00, ao, 5'd0} + {5'd0, ao, 2'd0};
    small_nxt = (ao100 < (IW+7)'(ah >> neg_shift));
    tv        = neg_r ? -$signed({1'b0, tm_r}) : $signed({1'b0, tm_r});
    den_t     = small_r ? a_r[33:0] : (a_r[33:0] + 34'(r_r));

    mv = '0;
    mf = '0;
    case (cmd.op)
      OP_MUL_S: begin
        mv = IW'(tv);
        mf = $signed({1'b0, c_r});
      end
      OP_MUL_TA: begin
        mv = piv_r;
        mf = tv;
      end
      OP_T1: begin
        mv = xv;
        mf = tau_r;
      end
      OP_T2: begin
        mv = yv + t1_r;
        mf = s_r;
      end
      OP_T3: begin
        mv = yv;
        mf = tau_r;
      end
      OP_T4: begin
        mv = xv - t3_r;
        mf = s_r;
      end
      default: begin
        mv = '0;
        mf = '0;
      end
    endcase
    mf_mag = mf[31] ? 32'(-mf) : 32'(mf);

    ar_start = 1'b1;
    ar_mode  = AR_MUL;
    ar_a     = 64'(magi(mv));
    ar_b     = 34'(mf_mag);
    case (cmd.op)
      OP_MUL_AA: begin
        ar_a = 64'(a_r);
        ar_b = a_r[33:0];
      end
      OP_MUL_BB: begin
        ar_a = 64'(b_r);
        ar_b = b_r[33:0];
      end
      OP_MUL_TT: begin
        ar_a = 64'(tm_r);
        ar_b = 34'(tm_r);
      end
      OP_SQRT: begin
        ar_mode = AR_SQRT;
        ar_a    = sq_r;
      end
      OP_DIV_TM: begin
        ar_mode = AR_DIV;
        ar_a    = {3'd0, b_r[30:0], 30'd0};
        ar_b    = den_t;
      end
      OP_DIV_C: begin
        ar_mode = AR_DIV;
        ar_a    = ONE_60;
        ar_b    = 34'(r_r);
      end
      OP_DIV_TAU: begin
        ar_mode = AR_DIV;
        ar_a    = {3'd0, 31'(s_r[31] ? -s_r : s_r), 30'd0};
        ar_b    = 34'(c_r) + 34'(ONE_30);
      end
      OP_MUL_S, OP_MUL_TA, OP_T1, OP_T2, OP_T3, OP_T4: begin
        ar_mode = AR_MUL;
      end
      default: begin
        ar_start = 1'b0;
      end
    endcase

    mq_mag = ar_res[IW+29:30];
    mq     = msign_r ? -$signed(mq_mag) : $signed(mq_mag);
    od_sum = (IW+2)'(magi(od_r[0])) + (IW+2)'(magi(od_r[1])) + (IW+2)'(magi(od_r[2]));

    stat.arith_done = ar_done;
    stat.norm_more  = small_r ? (a_r[IW-1:31] != '0) : ((a_r[IW-1:31] | b_r[IW-1:31]) != '0);
    stat.small_ang  = small_r;
    stat.sum_small  = (od_sum < (IW+2)'(zero_thr));
    stat.piv_big    = ((IW)'(zero_thr) < ao);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= OP_NONE;
      msign_r <= 1'b0;
    end else if (ar_start) begin
      pend_r  <= cmd.op;
      msign_r <= mv[IW-1] ^ mf[31];
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dg_r[0] <= IW'(diag_0);
        dg_r[1] <= IW'(diag_1);
        dg_r[2] <= IW'(diag_2);
        od_r[0] <= IW'(off_21);
        od_r[1] <= IW'(off_02);
        od_r[2] <= IW'(off_10);
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            um_r[i][j] <= (i == j) ? UW'(VEC_ONE) : '0;
          end
        end
      end
      OP_SETUP: begin
        piv_r   <= od_r[cmd.idx];
        small_r <= small_nxt;
        neg_r   <= (h != '0) && (h[IW-1] != od_r[cmd.idx][IW-1]);
        a_r     <= ah;
        b_r     <= small_nxt ? ao : IW'({ao, 1'b0});
      end
      OP_NORM: begin
        a_r <= a_r >> 1;
        b_r <= b_r >> 1;
      end
      OP_DIAG: begin
        od_r[cmd.idx] <= '0;
        dg_r[p]       <= clampv(dg_r[p] - ta_r, LIM_M);
        dg_r[q]       <= clampv(dg_r[q] + ta_r, LIM_M);
      end
      OP_WB: begin
        if (cmd.pair == 2'd0) begin
          od_r[q] <= clampv(xv - t2_r, LIM_M);
          od_r[p] <= clampv(yv + t4_r, LIM_M);
        end else begin
          um_r[p][col] <= UW'(clampv(xv - t2_r, LIM_U));
          um_r[q][col] <= UW'(clampv(yv + t4_r, LIM_U));
        end
      end
      OP_FIN: begin
        for (int i = 0; i < 3; i++) begin
          eig_r[i] <= DATA_BITS'((dg_r[i] > EMAX) ? EMAX : ((dg_r[i] < EMIN) ? EMIN : dg_r[i]));
          for (int j = 0; j < 3; j++) begin
            vec_r[i][j] <= DATA_BITS'(clampv(sxu(um_r[i][j]), VEC_ONE));
          end
        end
      end
      default: begin
      end
    endcase

    if (ar_done) begin
      case (pend_r)
        OP_MUL_AA:  sq_r <= ar_res[63:0];
        OP_MUL_BB:  sq_r <= sq_r + ar_res[63:0];
        OP_SQRT:    r_r  <= ar_res[31:0];
        OP_DIV_TM: begin
          if (den_t == '0) begin
            tm_r <= '0;
          end else if (ar_res[63:0] > 64'(ONE_30)) begin
            tm_r <= ONE_30;
          end else begin
            tm_r <= ar_res[30:0];
          end
        end
        OP_MUL_TT:  sq_r  <= ar_res[63:0] + ONE_60;
        OP_DIV_C:   c_r   <= ar_res[30:0];
        OP_MUL_S:   s_r   <= 32'(mq);
        OP_DIV_TAU: tau_r <= s_r[31] ? -$signed(ar_res[31:0]) : $signed(ar_res[31:0]);
        OP_MUL_TA:  ta_r  <= mq;
        OP_T1:      t1_r  <= mq;
        OP_T2:      t2_r  <= mq;
        OP_T3:      t3_r  <= mq;
        OP_T4:      t4_r  <= mq;
        default: begin
        end
      endcase
    end
  end

  assign eigval_0 = eig_r[0];
  assign eigval_1 = eig_r[1];
  assign eigval_2 = eig_r[2];
  assign vec0_x   = vec_r[0][0];
  assign vec0_y   = vec_r[0][1];
  assign vec0_z   = vec_r[0][2];
  assign vec1_x   = vec_r[1][0];
  assign vec1_y   = vec_r[1][1];
  assign vec1_z   = vec_r[1][2];
  assign vec2_x   = vec_r[2][0];
  assign vec2_y   = vec_r[2][1];
  assign vec2_z   = vec_r[2][2];

endmodule

// ===== design/jse3_ctrl.sv =====
// ----------------------------------------------------------------------------
// jse3_ctrl
// Sequencer for sweeps, pivots and the steps of one Jacobi rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "jacobi_symmetric_eigen_3x3_unit_assert.svh"

module jse3_ctrl
  import jse3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  logic [SWEEP_BITS-1:0] max_sweeps,
  output dp_cmd_t               cmd,
  input  dp_stat_t              stat
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SWEEP, ST_PIV, ST_PNEXT, ST_SETUP, ST_NORM, ST_SQA, ST_SQB,
    ST_SQRT, ST_DIVT, ST_TT, ST_SQRT2, ST_DIVC, ST_MULS, ST_DIVTAU, ST_MULTA,
    ST_DIAG, ST_T1, ST_T2, ST_T3, ST_T4, ST_WB, ST_WAIT, ST_FIN
  } state_t;

  state_t                state_r, state_nxt;
  state_t                ret_r, ret_nxt;
  logic [SWEEP_BITS-1:0] sw_r, sw_nxt;
  logic [1:0]            idx_r, idx_nxt;
  logic [1:0]            pair_r, pair_nxt;
  logic                  rot_r, rot_nxt;
  logic                  out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    sw_nxt        = sw_r;
    idx_nxt       = idx_r;
    pair_nxt      = pair_r;
    rot_nxt       = rot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.idx       = idx_r;
    cmd.pair      = pair_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          sw_nxt    = max_sweeps;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sw_r == '0 || stat.sum_small) begin
          state_nxt = ST_FIN;
        end else begin
          idx_nxt   = 2'd2;
          rot_nxt   = 1'b0;
          state_nxt = ST_PIV;
        end
      end
      ST_PIV: begin
        if (stat.piv_big) begin
          rot_nxt   = 1'b1;
          state_nxt = ST_SETUP;
        end else begin
          state_nxt = ST_PNEXT;
        end
      end
      ST_PNEXT: begin
        if (idx_r == 2'd0) begin
          sw_nxt    = sw_r - 1'b1;
          state_nxt = rot_r ? ST_SWEEP : ST_FIN;
        end else begin
          idx_nxt   = idx_r - 2'd1;
          state_nxt = ST_PIV;
        end
      end
      ST_SETUP: begin
        cmd.op    = OP_SETUP;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.norm_more) begin
          cmd.op = OP_NORM;
        end else if (stat.small_ang) begin
          state_nxt = ST_DIVT;
        end else begin
          state_nxt = ST_SQA;
        end
      end
      ST_SQA: begin
        cmd.op = OP_MUL_AA; ret_nxt = ST_SQB; state_nxt = ST_WAIT;
      end
      ST_SQB: begin
        cmd.op = OP_MUL_BB; ret_nxt = ST_SQRT; state_nxt = ST_WAIT;
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT; ret_nxt = ST_DIVT; state_nxt = ST_WAIT;
      end
      ST_DIVT: begin
        cmd.op = OP_DIV_TM; ret_nxt = ST_TT; state_nxt = ST_WAIT;
      end
      ST_TT: begin
        cmd.op = OP_MUL_TT; ret_nxt = ST_SQRT2; state_nxt = ST_WAIT;
      end
      ST_SQRT2: begin
        cmd.op = OP_SQRT; ret_nxt = ST_DIVC; state_nxt = ST_WAIT;
      end
      ST_DIVC: begin
        cmd.op = OP_DIV_C; ret_nxt = ST_MULS; state_nxt = ST_WAIT;
      end
      ST_MULS: begin
        cmd.op = OP_MUL_S; ret_nxt = ST_DIVTAU; state_nxt = ST_WAIT;
      end
      ST_DIVTAU: begin
        cmd.op = OP_DIV_TAU; ret_nxt = ST_MULTA; state_nxt = ST_WAIT;
      end
      ST_MULTA: begin
        cmd.op = OP_MUL_TA; ret_nxt = ST_DIAG; state_nxt = ST_WAIT;
      end
      ST_DIAG: begin
        cmd.op    = OP_DIAG;
        pair_nxt  = 2'd0;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        cmd.op = OP_T1; ret_nxt = ST_T2; state_nxt = ST_WAIT;
      end
      ST_T2: begin
        cmd.op = OP_T2; ret_nxt = ST_T3; state_nxt = ST_WAIT;
      end
      ST_T3: begin
        cmd.op = OP_T3; ret_nxt = ST_T4; state_nxt = ST_WAIT;
      end
      ST_T4: begin
        cmd.op = OP_T4; ret_nxt = ST_WB; state_nxt = ST_WAIT;
      end
      ST_WB: begin
        cmd.op = OP_WB;
        if (pair_r == 2'd3) begin
          state_nxt = ST_PNEXT;
        end else begin
          pair_nxt  = pair_r + 2'd1;
          state_nxt = ST_T1;
        end
      end
      ST_WAIT: begin
        if (stat.arith_done) begin
          state_nxt = ret_r;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      sw_r        <= '0;
      idx_r       <= '0;
      pair_r      <= '0;
      rot_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      sw_r        <= sw_nxt;
      idx_r       <= idx_nxt;
      pair_r      <= pair_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  `JSE3_ASSERT_IMP(a_wait_no_cmd, clk, rst_n, state_r == ST_WAIT, cmd.op == OP_NONE)
  `JSE3_ASSERT_NXT(a_load_sweep, clk, rst_n, in_valid && in_ready, state_r == ST_SWEEP)
  `JSE3_ASSERT_NXT(a_fin_valid, clk, rst_n, cmd.op == OP_FIN, out_valid_r && state_r == ST_IDLE)

endmodule

// ===== design/jacobi_symmetric_eigen_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// jacobi_symmetric_eigen_3x3_unit
// Eigen-decomposition of a symmetric 3x3 matrix by cyclic Jacobi sweeps.
// ----------------------------------------------------------------------------
// The request channel in_ch carries the three diagonal and three off-diagonal
// entries in signed Q16.16. The result channel out_ch returns three saturated
// eigenvalues and the rows of the Q1.30 rotation matrix, one result per
// request. Both use valid/ready; a transfer happens when both are high.
// The cfg port writes max_sweeps, zero_threshold and negligible_shift.
// The user must write them while the unit is idle; it does not enforce this.
// A request is taken only when the unit is idle. Each sweep checks the
// off-diagonal sum and visits three pivots; a pivot is rotated only when its
// magnitude exceeds zero_threshold; a rotation takes three divides on the
// one-bit-per-cycle divider, up to two square roots and up to nine
// normalizing shifts. The unit runs at most max_sweeps sweeps, stops after
// a sweep with no rotation, and goes straight to the result when the
// off-diagonal sum is below zero_threshold. The finished result sits in an
// output register; while the receiver stalls the unit still accepts and works
// on the next request, and holds it at the end until the output is free.
// Reset returns the registers to their defaults and empties the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jacobi_symmetric_eigen_3x3_unit
  import jse3_pkg::*;
#(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  jse3_in_if.sink                  in_ch,
  jse3_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [SWEEP_BITS-1:0] max_sweeps_r;
  logic [THR_BITS-1:0]   zero_thr_r;
  logic [SHIFT_BITS-1:0] neg_shift_r;
  dp_cmd_t               cmd;
  dp_stat_t              stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sweeps_r <= MAX_SWEEPS_RST;
      zero_thr_r   <= ZERO_THRESHOLD_RST;
      neg_shift_r  <= NEGLIGIBLE_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MAX_SWEEPS:       max_sweeps_r <= cfg_data[SWEEP_BITS-1:0];
        CFG_ZERO_THRESHOLD:   zero_thr_r   <= cfg_data[THR_BITS-1:0];
        CFG_NEGLIGIBLE_SHIFT: neg_shift_r  <= cfg_data[SHIFT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  jse3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .max_sweeps (max_sweeps_r),
    .cmd        (cmd),
    .stat       (stat)
  );

  jse3_dpath #(
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .zero_thr  (zero_thr_r),
    .neg_shift (neg_shift_r),
    .diag_0    (in_ch.diag_0),
    .diag_1    (in_ch.diag_1),
    .diag_2    (in_ch.diag_2),
    .off_21    (in_ch.off_21),
    .off_02    (in_ch.off_02),
    .off_10    (in_ch.off_10),
    .eigval_0  (out_ch.eigval_0),
    .eigval_1  (out_ch.eigval_1),
    .eigval_2  (out_ch.eigval_2),
    .vec0_x    (out_ch.vec0_x),
    .vec0_y    (out_ch.vec0_y),
    .vec0_z    (out_ch.vec0_z),
    .vec1_x    (out_ch.vec1_x),
    .vec1_y    (out_ch.vec1_y),
    .vec1_z    (out_ch.vec1_z),
    .vec2_x    (out_ch.vec2_x),
    .vec2_y    (out_ch.vec2_y),
    .vec2_z    (out_ch.vec2_z)
  );

endmodule

// ===== bench/jse3_tb_if.sv =====
// ----------------------------------------------------------------------------
// jse3_tb_if
// Bench-side configuration port interface for the 3x3 symmetric eigen unit.
// ----------------------------------------------------------------------------
// The unit's own request and result interfaces are instantiated directly by
// the bench; this file only gathers the configuration port signals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface jse3_cfg_if;
  import jse3_pkg::*;
  logic                     we;
  logic [CFG_IDX_BITS-1:0]  idx;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output we, idx, data);
  modport sink (input we, idx, data);
endinterface

// ===== bench/jacobi_symmetric_eigen_3x3_unit_tb.sv =====
// ----------------------------------------------------------------------------
// jacobi_symmetric_eigen_3x3_unit_tb
// Self-checking bench for the 3x3 symmetric Jacobi eigen unit.
// ----------------------------------------------------------------------------
// Matrices are sent over the request channel under random idling and a long
// receiver hold-off. A bit-exact fixed-point predictor computes eigenvalues
// and rotation rows for each accepted request; a checker compares results in
// order. Several register settings are covered, the extremes among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jacobi_symmetric_eigen_3x3_unit_tb;
  import jse3_pkg::*;

  typedef logic signed [31:0] word_t;
  typedef struct {
    word_t eig[3];
    word_t vec[3][3];
  } eigen_res_t;

  localparam longint VEC_ONE   = 64'sd1 << 30;
  localparam longint VEC_LIM   = 64'sd1 << 31;
  localparam longint INNER_LIM = 64'sd1 << 38;
  localparam int     LAT_TAIL  = 30000;

  logic clk;
  logic rst_n;

  jse3_in_if  #(.DATA_BITS(32)) in_ch ();
  jse3_out_if #(.DATA_BITS(32)) out_ch ();
  jse3_cfg_if cfg ();

  jacobi_symmetric_eigen_3x3_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg.we),
    .cfg_idx (cfg.idx),
    .cfg_data(cfg.data)
  );

  logic [5:0]  sweep_limit;
  logic [15:0] zero_thr;
  logic [4:0]  neg_shift;

  eigen_res_t expected_q[$];
  int         fail_count;
  bit         idle_on;
  int         hold_off;

  longint md[3];
  longint mo[3];
  longint mu[3][3];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5000ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp64(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint qmul(longint v, longint f);
    longint unsigned a, b, r;
    a = mag64(v);
    b = mag64(f);
    r = (((a >> 32) * b) << 2) + (((a & 64'hFFFF_FFFF) * b) >> 30);
    return ((v < 0) != (f < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void apply_rotation(int i);
    int p, q;
    longint piv, h, t, c, s, tau, ta, oq, op, ua, ub;
    longint unsigned ao, ah, a, b, tm, r2, sm, den;
    bit neg;
    p = (i + 1) % 3;
    q = (p + 1) % 3;
    piv = mo[i];
    h = md[q] - md[p];
    ao = mag64(piv);
    ah = mag64(h);
    neg = (h != 0) && ((h < 0) != (piv < 0));
    if (ao * 100 < (ah >> neg_shift)) begin
      a = ah;
      b = ao;
      while (a >= 64'd1 << 31) begin
        a >>= 1;
        b >>= 1;
      end
      tm = a != 0 ? (b << 30) / a : 0;
    end else begin
      a = ah;
      b = 2 * ao;
      while ((a | b) >= 64'd1 << 31) begin
        a >>= 1;
        b >>= 1;
      end
      den = a + root64(a * a + b * b);
      tm = den != 0 ? (b << 30) / den : 0;
    end
    if (tm > VEC_ONE) tm = VEC_ONE;
    t = neg ? -longint'(tm) : longint'(tm);
    r2 = root64(tm * tm + (64'd1 << 60));
    c = longint'((64'd1 << 60) / r2);
    s = qmul(t, c);
    sm = (mag64(s) << 30) / (longint'(c) + VEC_ONE);
    tau = s < 0 ? -longint'(sm) : longint'(sm);
    ta = qmul(piv, t);
    mo[i] = 0;
    md[p] = clamp64(md[p] - ta, INNER_LIM);
    md[q] = clamp64(md[q] + ta, INNER_LIM);
    oq = mo[q];
    op = mo[p];
    mo[q] = clamp64(oq - qmul(op + qmul(oq, tau), s), INNER_LIM);
    mo[p] = clamp64(op + qmul(oq - qmul(op, tau), s), INNER_LIM);
    for (int j = 2; j >= 0; j--) begin
      ua = mu[p][j];
      ub = mu[q][j];
      mu[p][j] = clamp64(ua - qmul(ub + qmul(ua, tau), s), VEC_LIM);
      mu[q][j] = clamp64(ub + qmul(ua - qmul(ub, tau), s), VEC_LIM);
    end
  endfunction

  function automatic eigen_res_t diagonalize(word_t dg[3], word_t od[3]);
    eigen_res_t r;
    longint unsigned sum;
    bit done;
    int sw;
    for (int i = 0; i < 3; i++) begin
      md[i] = dg[i];
      mo[i] = od[i];
      for (int j = 0; j < 3; j++) mu[i][j] = (i == j) ? VEC_ONE : 0;
    end
    done = 0;
    for (sw = sweep_limit; sw > 0 && !done; sw--) begin
      sum = mag64(mo[0]) + mag64(mo[1]) + mag64(mo[2]);
      done = sum < zero_thr;
      if (!done) begin
        done = 1;
        for (int i = 2; i >= 0; i--) begin
          if (zero_thr < mag64(mo[i])) begin
            done = 0;
            apply_rotation(i);
          end
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.eig[i] = word_t'(clamp64(md[i] + 0, 64'sd2147483647) < -64'sd2147483648 ?
                 -64'sd2147483648 : clamp64(md[i], 64'sd2147483648) > 64'sd2147483647 ?
                 64'sd2147483647 : clamp64(md[i], 64'sd2147483648));
      for (int j = 0; j < 3; j++) r.vec[i][j] = word_t'(clamp64(mu[i][j], VEC_ONE));
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
    cfg.we   <= 1'b1;
    cfg.idx  <= idx;
    cfg.data <= val;
    @(posedge clk);
    cfg.we   <= 1'b0;
    case (idx)
      CFG_MAX_SWEEPS:     sweep_limit = val[5:0];
      CFG_ZERO_THRESHOLD: zero_thr = val;
      default:            neg_shift = val[4:0];
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LAT_TAIL) @(posedge clk);
  endtask

  task automatic set_regs(logic [5:0] sw, logic [15:0] thr, logic [4:0] sh);
    drain();
    write_reg(CFG_MAX_SWEEPS, {10'd0, sw});
    write_reg(CFG_ZERO_THRESHOLD, thr);
    write_reg(CFG_NEGLIGIBLE_SHIFT, {11'd0, sh});
  endtask

  task automatic send_matrix(word_t d0, word_t d1, word_t d2,
                             word_t o21, word_t o02, word_t o10);
    word_t dg[3];
    word_t od[3];
    while (idle_on && $urandom_range(99) < 17) @(posedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.diag_0 <= d0;
    in_ch.diag_1 <= d1;
    in_ch.diag_2 <= d2;
    in_ch.off_21 <= o21;
    in_ch.off_02 <= o02;
    in_ch.off_10 <= o10;
    do @(posedge clk); while (!in_ch.ready);
    dg = '{d0, d1, d2};
    od = '{o21, o02, o10};
    expected_q.push_back(diagonalize(dg, od));
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic word_t rand_entry();
    case ($urandom_range(5))
      0:       return word_t'($urandom);
      1:       return word_t'($urandom_range(8) - 4);
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return word_t'(int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  task automatic send_random(int n);
    repeat (n) send_matrix(rand_entry(), rand_entry(), rand_entry(),
                           rand_entry(), rand_entry(), rand_entry());
  endtask

  task automatic check_field(string name, word_t exp_v, word_t act_v);
    if (exp_v !== act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        eigen_res_t e;
        e = expected_q.pop_front();
        check_field("eigval_0", e.eig[0], out_ch.eigval_0);
        check_field("eigval_1", e.eig[1], out_ch.eigval_1);
        check_field("eigval_2", e.eig[2], out_ch.eigval_2);
        check_field("vec0_x", e.vec[0][0], out_ch.vec0_x);
        check_field("vec0_y", e.vec[0][1], out_ch.vec0_y);
        check_field("vec0_z", e.vec[0][2], out_ch.vec0_z);
        check_field("vec1_x", e.vec[1][0], out_ch.vec1_x);
        check_field("vec1_y", e.vec[1][1], out_ch.vec1_y);
        check_field("vec1_z", e.vec[1][2], out_ch.vec1_z);
        check_field("vec2_x", e.vec[2][0], out_ch.vec2_x);
        check_field("vec2_y", e.vec[2][1], out_ch.vec2_y);
        check_field("vec2_z", e.vec[2][2], out_ch.vec2_z);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(idle_on && $urandom_range(99) < 17);
    end
  end

  task automatic test_directed();
    send_matrix(0, 0, 0, 0, 0, 0);
    send_matrix(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0);
    send_matrix(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    send_matrix(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_matrix(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_matrix(32'sh4000_0000, -32'sh4000_0000, 0, 5, -3, 2);
    send_matrix(-1, -1, -1, -1, -1, -1);
    send_matrix(32'sh0100_0000, 0, 32'sh0000_1000, 1, 2, 3);
  endtask

  task automatic test_register_extremes();
    set_regs(6'd0, 16'd1, 5'd24);
    send_matrix(32'sh0001_0000, 2, 3, 32'sh0000_4000, 7, 9);
    set_regs(6'd63, 16'd0, 5'd0);
    send_matrix(32'sh0003_0000, 32'sh0001_0000, 0, 32'sh0000_0100, -5, 11);
    send_random(8);
    set_regs(6'd1, 16'hFFFF, 5'd31);
    send_matrix(32'sh0001_0000, 0, 0, 32'sh0000_FFFF, 32'sh0001_0000, 32'sh1_0000);
    send_random(8);
    set_regs(6'd5, 16'd16, 5'd8);
    send_matrix(32'sh1000_0000, 0, -32'sh1000_0000, 3, 100, -7);
    send_random(8);
  endtask

  task automatic test_backpressure();
    set_regs(6'd20, 16'd1, 5'd24);
    hold_off = 60000;
    send_random(4);
    drain();
  endtask

  task automatic test_random(int n);
    idle_on = 1'b0;
    send_random(60);
    idle_on = 1'b1;
    for (int k = 0; k < n; k += 100) begin
      if (k == 500)
        set_regs(6'($urandom_range(63, 1)), 16'($urandom_range(65535)),
                 5'($urandom_range(31)));
      send_random(100);
    end
  endtask

  initial begin
    fail_count = 0;
    idle_on = 1'b1;
    hold_off = 0;
    sweep_limit = MAX_SWEEPS_RST;
    zero_thr = ZERO_THRESHOLD_RST;
    neg_shift = NEGLIGIBLE_SHIFT_RST;
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.diag_0 <= '0;
    in_ch.diag_1 <= '0;
    in_ch.diag_2 <= '0;
    in_ch.off_21 <= '0;
    in_ch.off_02 <= '0;
    in_ch.off_10 <= '0;
    cfg.we <= 1'b0;
    cfg.idx <= '0;
    cfg.data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random(940);
    drain();
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
